>>> hdl/merkle_proof_verifier_macros.svh
// Assertion macros for the Merkle proof verifier.
`ifndef MERKLE_PROOF_VERIFIER_MACROS_SVH
`define MERKLE_PROOF_VERIFIER_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define MPV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define MPV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hdl/mpv_pkg.sv
// Shared types, constants and SHA-256 helpers for the Merkle proof verifier.
package mpv_pkg;
  localparam int WordW = 64;
  localparam int CfgAddrW = 5;
  localparam logic [1:0] CMD_LEAF = 2'd0;
  localparam logic [1:0] CMD_LEFT = 2'd1;
  localparam logic [1:0] CMD_RIGHT = 2'd2;
  localparam logic [1:0] CMD_PARENT = 2'd3;
  localparam logic [1:0] FAIL_NONE = 2'd0;
  localparam logic [1:0] FAIL_ROOT = 2'd1;
  localparam logic [1:0] FAIL_CHILD = 2'd2;
  localparam logic [1:0] FAIL_PARENT = 2'd3;
  localparam logic [CfgAddrW-1:0] ADDR_ROOT0 = 5'd0;
  localparam logic [CfgAddrW-1:0] ADDR_ROOT1 = 5'd8;
  localparam logic [CfgAddrW-1:0] ADDR_ROOT2 = 5'd16;
  localparam logic [CfgAddrW-1:0] ADDR_ROOT3 = 5'd24;

  typedef logic [255:0] hash_t;
  typedef logic [511:0] block_t;

  // request from the sequencer to the compression core
  typedef struct packed {
    logic   start;
    logic   from_init;
    block_t blk;
  } sha_req_t;

  typedef struct packed {
    logic  done;
    hash_t digest;
  } sha_rsp_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  localparam logic [255:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // byte-addressed little-endian words into big-endian SHA words; word 0 in top bits
  function automatic logic [255:0] words_to_be(input logic [255:0] w);
    logic [255:0] r;
    for (int i = 0; i < 32; i++) r[255-8*i -: 8] = w[8*i +: 8];
    return r;
  endfunction
endpackage

>>> hdl/mpv_sha_core.sv
// SHA-256 compression core: one round per cycle over a 16-word schedule window.
module mpv_sha_core (
  input  logic               clk,
  input  logic               rst,
  input  mpv_pkg::sha_req_t  req,
  output mpv_pkg::sha_rsp_t  rsp
);
  import mpv_pkg::*;

  logic [31:0] hv [8];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] w [16];
  logic [5:0]  round;
  logic        busy;
  logic        last_round;
  logic        done;

  logic [31:0] s0w, s1w, wt, t1, t2, ep0, ep1, ch, maj;

  assign s0w = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign s1w = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
  assign wt  = (round < 6'd16) ? w[0] : (s1w + w[9] + s0w + w[0]);
  assign ep1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign ep0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign ch  = (e & f) ^ (~e & g);
  assign maj = (a & b) ^ (a & c) ^ (b & c);
  assign t1  = h + ep1 + ch + round_k(round) + wt;
  assign t2  = ep0 + maj;
  assign last_round = busy && (round == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      round <= '0;
      done  <= 1'b0;
    end else begin
      done <= last_round;
      if (req.start) begin
        busy  <= 1'b1;
        round <= '0;
      end else if (busy) begin
        round <= round + 6'd1;
        if (last_round) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      for (int i = 0; i < 8; i++) begin
        if (req.from_init) hv[i] <= INIT_H[255-32*i -: 32];
      end
      {a, b, c, d, e, f, g, h} <= req.from_init ? INIT_H :
                                  {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
      for (int i = 0; i < 16; i++) w[i] <= req.blk[511-32*i -: 32];
    end else if (busy) begin
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
      if (last_round) begin
        hv[0] <= hv[0] + t1 + t2; hv[1] <= hv[1] + a; hv[2] <= hv[2] + b;
        hv[3] <= hv[3] + c;       hv[4] <= hv[4] + d + t1; hv[5] <= hv[5] + e;
        hv[6] <= hv[6] + f;       hv[7] <= hv[7] + g;
      end
    end
  end

  assign rsp = {done, hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
endmodule

>>> hdl/merkle_proof_verifier.sv
// Top level of the Merkle proof verifier: word intake, node sequencer, verdict.
//   channel   dir  fields
//   s_axis    in   tdata {data_word, word_index}, tuser command, tlast proof_end
//   m_axis    out  tdata {fail_kind, accepted}
//   apb       cfg  root_word0..3 at 0x00, 0x08, 0x10, 0x18
// Leaf, child words and parent words 0..2 are stored without a hash step.
// Parent word 3 runs three SHA-256 compressions of 64 rounds before the next word is taken.
// The compression core sets the node time; s_axis_tready is low throughout.
// Synchronous reset clears running hash, node count, failure code and output valid.
// A held verdict stalls the input until it is taken.
module merkle_proof_verifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // word_index[1:0], data_word[65:2]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // accepted[0], fail_kind[2:1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import mpv_pkg::*;
`include "merkle_proof_verifier_macros.svh"

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PASS1 = 5'b00010,
    ST_PASS2 = 5'b00100,
    ST_PASS3 = 5'b01000,
    ST_CHECK = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [63:0] root [4];
  logic [63:0] run_h [4];
  logic [63:0] lbuf [4];
  logic [63:0] rbuf [4];
  logic [63:0] pbuf [4];
  logic [15:0] node_count;
  logic [1:0]  first_failure;
  logic        pend_last;
  logic        out_valid;
  logic [1:0]  out_kind;

  sha_req_t req;
  sha_rsp_t rsp;

  logic [1:0]  in_cmd, in_idx;
  logic [63:0] in_data;
  logic        in_last, in_fire, out_fire, node_go;
  logic [255:0] node_h, root_v, run_v, left_v, right_v, par_v;
  logic [255:0] run_w, par_w;

  assign in_cmd  = s_axis_tuser;
  assign in_idx  = s_axis_tdata[1:0];
  assign in_data = s_axis_tdata[65:2];
  assign in_last = s_axis_tlast;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !(out_valid && !m_axis_tready);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign node_go = in_fire && in_cmd == CMD_PARENT && in_idx == 2'd3;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {5'd0, out_kind, out_kind == FAIL_NONE};
  assign pready = 1'b1;

  assign root_v  = {root[3], root[2], root[1], root[0]};
  assign run_v   = {run_h[3], run_h[2], run_h[1], run_h[0]};
  assign left_v  = {lbuf[3], lbuf[2], lbuf[1], lbuf[0]};
  assign right_v = {rbuf[3], rbuf[2], rbuf[1], rbuf[0]};
  assign par_v   = {pbuf[3], pbuf[2], pbuf[1], pbuf[0]};

  // hashes with the incoming word already in place
  always_comb begin
    run_w = run_v;
    par_w = par_v;
    if (in_cmd == CMD_LEAF) run_w[64*in_idx +: 64] = in_data;
    if (in_cmd == CMD_PARENT) par_w[64*in_idx +: 64] = in_data;
  end

  // big-endian digest back to byte-addressed little-endian words
  always_comb begin
    for (int i = 0; i < 32; i++) node_h[8*i +: 8] = rsp.digest[255-8*i -: 8];
  end

  mpv_sha_core u_core (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always_comb begin
    state_next = state;
    req.start = 1'b0;
    req.from_init = 1'b1;
    req.blk = '0;
    unique case (state)
      ST_IDLE: if (node_go) begin
        state_next = ST_PASS1;
        req.start = 1'b1;
        req.blk = {words_to_be(left_v), words_to_be(right_v)};
      end
      ST_PASS1: if (rsp.done) begin
        state_next = ST_PASS2;
        req.start = 1'b1;
        req.from_init = 1'b0;
        req.blk = {32'h80000000, 448'd0, 32'd512};
      end
      ST_PASS2: if (rsp.done) begin
        state_next = ST_PASS3;
        req.start = 1'b1;
        req.blk = {rsp.digest, 32'h80000000, 192'd0, 32'd256};
      end
      ST_PASS3: if (rsp.done) state_next = ST_CHECK;
      ST_CHECK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < 4; i++) begin
        root[i] <= '0;
        run_h[i] <= '0;
      end
      node_count <= '0;
      first_failure <= FAIL_NONE;
      pend_last <= 1'b0;
      out_valid <= 1'b0;
      out_kind <= FAIL_NONE;
    end else begin
      state <= state_next;
      if (out_fire) out_valid <= 1'b0;
      if (psel && penable && pwrite && pready) begin
        unique case (paddr)
          ADDR_ROOT0: root[0] <= pwdata;
          ADDR_ROOT1: root[1] <= pwdata;
          ADDR_ROOT2: root[2] <= pwdata;
          ADDR_ROOT3: root[3] <= pwdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        unique case (in_cmd)
          CMD_LEAF:  run_h[in_idx] <= in_data;
          CMD_LEFT:  lbuf[in_idx] <= in_data;
          CMD_RIGHT: rbuf[in_idx] <= in_data;
          CMD_PARENT: pbuf[in_idx] <= in_data;
          default: ;
        endcase
      end
      // verdict without a node step
      if (in_fire && in_last && !node_go) begin
        out_valid <= 1'b1;
        if (node_count == 16'd0) out_kind <= (run_w == root_v) ? FAIL_NONE : FAIL_ROOT;
        else if (par_w != root_v) out_kind <= FAIL_ROOT;
        else if (first_failure != FAIL_NONE) out_kind <= first_failure;
        else out_kind <= (run_w == root_v) ? FAIL_NONE : FAIL_ROOT;
        for (int i = 0; i < 4; i++) run_h[i] <= '0;
        node_count <= '0;
        first_failure <= FAIL_NONE;
      end
      if (node_go) begin
        pend_last <= in_last;
        if (first_failure == FAIL_NONE && left_v != run_v && right_v != run_v)
          first_failure <= FAIL_CHILD;
      end
      if (state == ST_PASS3 && rsp.done) begin
        for (int i = 0; i < 4; i++) run_h[i] <= node_h[64*i +: 64];
      end
      if (state == ST_CHECK) begin
        if (pend_last) begin
          // node not counted here; node_count is not used for this verdict
          out_valid <= 1'b1;
          if (par_v != root_v) out_kind <= FAIL_ROOT;
          else if (first_failure != FAIL_NONE) out_kind <= first_failure;
          else if (run_v != par_v) out_kind <= FAIL_PARENT;
          else out_kind <= FAIL_NONE;
          for (int i = 0; i < 4; i++) run_h[i] <= '0;
          node_count <= '0;
          first_failure <= FAIL_NONE;
        end else begin
          if (node_count != 16'hFFFF) node_count <= node_count + 16'd1;
          if (first_failure == FAIL_NONE && run_v != par_v) first_failure <= FAIL_PARENT;
        end
      end
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_ROOT0: prdata = root[0];
      ADDR_ROOT1: prdata = root[1];
      ADDR_ROOT2: prdata = root[2];
      ADDR_ROOT3: prdata = root[3];
      default: prdata = '0;
    endcase
  end

  `MPV_ASSERT_IMP(a_busy_not_ready, clk, rst, state != ST_IDLE, !s_axis_tready, "ready while hashing")
  `MPV_ASSERT_NEXT(a_node_start, clk, rst, node_go, state == ST_PASS1, "node not started")
  `MPV_ASSERT_IMP(a_done_in_pass, clk, rst, rsp.done, state == ST_PASS1 || state == ST_PASS2 || state == ST_PASS3, "stray core done")
endmodule
